FILE: src/ags_pkg.sv
// Shared types, constants and constant functions of the gimbal angle setpoint generator.
package ags_pkg;

	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam int STICK_W = 16;
	localparam int STICK_FRAC = 14;

	localparam longint PI_Q29 = 64'sd1686629713;
	localparam longint STEP10_Q29 = 64'sd93701651;
	localparam longint STEP5_Q29 = 64'sd46850825;

	localparam int STICK_HI = 16221;
	localparam int STICK_LO = 8192;
	localparam int REV_GAP = 200;

	localparam longint WIN_YAW_NUM = 175;
	localparam longint WIN_YAW_DEN = 1000;
	localparam longint WIN_PITCH_NUM = 14;
	localparam longint WIN_PITCH_DEN = 100;

	localparam longint SENS_RST_Q13 = 8;
	localparam longint PITCH_LIM_Q13 = 4096;

	typedef enum logic [1:0] {
		PWR_DEAD,
		PWR_RESURRECT,
		PWR_WORKING
	} pwr_state_t;

	typedef enum logic [1:0] {
		CFG_YAW_SENS,
		CFG_PITCH_SENS,
		CFG_PITCH_MIN,
		CFG_PITCH_MAX
	} cfg_idx_t;

	// rescale a Q29 constant to frac fraction bits, round half up; for frac of 29 or more the value is returned unchanged
	function automatic longint q29_to(longint v, int frac);
		longint r;
		if (frac >= 29) begin
			r = v;
		end else begin
			r = (v + (longint'(1) <<< (28 - frac))) >>> (29 - frac);
		end
		return r;
	endfunction

	// rescale a Q13 constant to frac fraction bits, round half up
	function automatic longint q13_to(longint v, int frac);
		longint r;
		if (frac >= 13) begin
			r = v <<< (frac - 13);
		end else begin
			r = (v + (longint'(1) <<< (12 - frac))) >>> (13 - frac);
		end
		return r;
	endfunction

endpackage

FILE: src/ags_wrap.sv
// Wraps a widened angle sum into [-pi, pi) by subtracting a multiple of 2*pi.
module ags_wrap #(
	parameter int ANGLE_WIDTH = ags_pkg::ANGLE_WIDTH_DEF
) (
	input  logic signed [ANGLE_WIDTH+1:0] sum,
	output logic signed [ANGLE_WIDTH-1:0] wrapped
);
	import ags_pkg::*;

	localparam int FRAC = ANGLE_WIDTH - 3;
	localparam int XW = ANGLE_WIDTH + 4;
	localparam longint PI_L = q29_to(PI_Q29, FRAC);
	localparam logic signed [XW-1:0] P1 = XW'(PI_L);
	localparam logic signed [XW-1:0] P2 = XW'(2 * PI_L);
	localparam logic signed [XW-1:0] P3 = XW'(3 * PI_L);
	localparam logic signed [XW-1:0] P4 = XW'(4 * PI_L);

	logic signed [XW-1:0] x;
	logic signed [XW-1:0] y;

	assign x = XW'(sum);

	always_comb begin
		priority if (x >= P3) begin
			y = x - P4;
		end else if (x >= P1) begin
			y = x - P2;
		end else if (x >= -P1) begin
			y = x;
		end else if (x >= -P3) begin
			y = x + P2;
		end else begin
			y = x + P4;
		end
	end

	assign wrapped = y[ANGLE_WIDTH-1:0];

endmodule

FILE: src/gimbal_angle_setpoint_generator.sv
// Gimbal angle setpoint generator: power phase machine and yaw/pitch reference update.
// From input beat to result beat: input register, product register, result register.
// Throughput: one beat per cycle unless out_stall holds the output; the reference
// feedback loop closes inside the result stage, so back-to-back ticks see the previous
// reference. Reset: pipeline empty, power state dead, references zero, motor pitch
// basis, step armed, reversal gap counter zero, config registers at their defaults.
module gimbal_angle_setpoint_generator #(
	parameter int ANGLE_WIDTH = ags_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ags_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [ags_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [ags_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              any_motor_on,
	input  logic                              referee_power_on,
	input  logic                              auto_mode,
	input  logic                              pid_test_mode,
	input  logic                              target_seen,
	input  logic signed [ANGLE_WIDTH-1:0]     vision_yaw,
	input  logic signed [ANGLE_WIDTH-1:0]     vision_pitch,
	input  logic signed [ags_pkg::STICK_W-1:0] stick_yaw,
	input  logic signed [ags_pkg::STICK_W-1:0] stick_pitch,
	input  logic                              reverse_request,
	input  logic signed [ANGLE_WIDTH-1:0]     imu_yaw,
	input  logic signed [ANGLE_WIDTH-1:0]     motor_pitch,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ANGLE_WIDTH-1:0]     yaw_reference,
	output logic signed [ANGLE_WIDTH-1:0]     pitch_reference,
	output logic [1:0]                        power_state
);
	import ags_pkg::*;

	localparam int W = ANGLE_WIDTH;
	localparam int FRAC = W - 3;
	localparam int SENS_W = W - 1;
	localparam int PW = W + STICK_W;
	localparam int SW = W + 2;
	localparam int AW = STICK_W + 1;

	localparam longint PI_L = q29_to(PI_Q29, FRAC);
	localparam longint STEP10_L = q29_to(STEP10_Q29, FRAC);
	localparam longint STEP5_L = q29_to(STEP5_Q29, FRAC);
	localparam longint YAW_WIN = ((WIN_YAW_NUM <<< FRAC) - 1) / WIN_YAW_DEN;
	localparam longint PITCH_WIN = ((WIN_PITCH_NUM <<< FRAC) - 1) / WIN_PITCH_DEN;

	localparam logic signed [SW-1:0] PI_V = SW'(PI_L);
	localparam logic signed [SW-1:0] STEP10_V = SW'(STEP10_L);
	localparam logic signed [SW-1:0] STEP5_V = SW'(STEP5_L);
	localparam logic [W:0] YAW_WIN_V = (W + 1)'(YAW_WIN);
	localparam logic [W:0] PITCH_WIN_V = (W + 1)'(PITCH_WIN);
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(longint'(1) <<< (STICK_FRAC - 1));

	localparam logic [SENS_W-1:0] SENS_RST = SENS_W'(q13_to(SENS_RST_Q13, FRAC));
	localparam logic signed [W-1:0] PMIN_RST = W'(q13_to(-PITCH_LIM_Q13, FRAC));
	localparam logic signed [W-1:0] PMAX_RST = W'(q13_to(PITCH_LIM_Q13, FRAC));

	// config registers
	logic [SENS_W-1:0]     yaw_sens_q;
	logic [SENS_W-1:0]     pitch_sens_q;
	logic signed [W-1:0]   pitch_min_q;
	logic signed [W-1:0]   pitch_max_q;
	cfg_idx_t              cfg_sel;
	logic                  cfg_wr;

	assign pready = 1'b1;
	assign cfg_sel = cfg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_sens_q <= SENS_RST;
			pitch_sens_q <= SENS_RST;
			pitch_min_q <= PMIN_RST;
			pitch_max_q <= PMAX_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				CFG_YAW_SENS:   yaw_sens_q <= pwdata[SENS_W-1:0];
				CFG_PITCH_SENS: pitch_sens_q <= pwdata[SENS_W-1:0];
				CFG_PITCH_MIN:  pitch_min_q <= pwdata[W-1:0];
				CFG_PITCH_MAX:  pitch_max_q <= pwdata[W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			CFG_YAW_SENS:   prdata = CFG_DATA_W'(yaw_sens_q);
			CFG_PITCH_SENS: prdata = CFG_DATA_W'(pitch_sens_q);
			CFG_PITCH_MIN:  prdata = CFG_DATA_W'($unsigned(pitch_min_q));
			CFG_PITCH_MAX:  prdata = CFG_DATA_W'($unsigned(pitch_max_q));
		endcase
	end

	// pipeline control
	logic valid_s1, valid_s2, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_out;
	logic acc_in, adv1, adv2;

	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy_s2 = !valid_s2 || rdy_out;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign acc_in = in_valid && rdy_s1;
	assign adv1 = valid_s1 && rdy_s2;
	assign adv2 = valid_s2 && rdy_out;
	assign in_stall = !rdy_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// stage 1: input register
	logic                       any_s1, refp_s1, auto_s1, test_s1, seen_s1, rev_s1;
	logic signed [W-1:0]        vis_yaw_s1, vis_pitch_s1, imu_yaw_s1, mot_pitch_s1;
	logic signed [STICK_W-1:0]  stk_yaw_s1, stk_pitch_s1;

	always_ff @(posedge clk) begin
		if (acc_in) begin
			any_s1 <= any_motor_on;
			refp_s1 <= referee_power_on;
			auto_s1 <= auto_mode;
			test_s1 <= pid_test_mode;
			seen_s1 <= target_seen;
			rev_s1 <= reverse_request;
			vis_yaw_s1 <= vision_yaw;
			vis_pitch_s1 <= vision_pitch;
			imu_yaw_s1 <= imu_yaw;
			mot_pitch_s1 <= motor_pitch;
			stk_yaw_s1 <= stick_yaw;
			stk_pitch_s1 <= stick_pitch;
		end
	end

	// stage 2: products, windows, stick thresholds
	logic signed [PW-1:0] prod_y, prod_p, rnd_y, rnd_p;
	logic signed [W:0]    dyaw, dpitch;
	logic [W:0]           ayaw, apitch;
	logic [AW-1:0]        astk_y, astk_p;
	logic                 win;

	assign prod_y = stk_yaw_s1 * $signed({1'b0, yaw_sens_q});
	assign prod_p = stk_pitch_s1 * $signed({1'b0, pitch_sens_q});
	assign rnd_y = prod_y + ROUND_HALF;
	assign rnd_p = prod_p + ROUND_HALF;

	assign dyaw = imu_yaw_s1 - vis_yaw_s1;
	assign dpitch = mot_pitch_s1 - vis_pitch_s1;
	assign ayaw = dyaw[W] ? (W + 1)'(-dyaw) : dyaw;
	assign apitch = dpitch[W] ? (W + 1)'(-dpitch) : dpitch;
	assign win = seen_s1 && (ayaw <= YAW_WIN_V) && (apitch <= PITCH_WIN_V);

	assign astk_y = stk_yaw_s1[STICK_W-1] ? AW'(-AW'(stk_yaw_s1)) : AW'(stk_yaw_s1);
	assign astk_p = stk_pitch_s1[STICK_W-1] ? AW'(-AW'(stk_pitch_s1)) : AW'(stk_pitch_s1);

	logic                pwr_on_s2, any_s2, auto_s2, test_s2, win_s2, rev_s2;
	logic signed [W-1:0] vis_yaw_s2, vis_pitch_s2, mot_pitch_s2;
	logic signed [W:0]   dy_s2, dp_s2;
	logic                yaw_hi_s2, pitch_hi_s2, both_lo_s2, yaw_neg_s2, pitch_neg_s2;

	always_ff @(posedge clk) begin
		if (adv1) begin
			pwr_on_s2 <= any_s1 | refp_s1;
			any_s2 <= any_s1;
			auto_s2 <= auto_s1;
			test_s2 <= test_s1;
			win_s2 <= win;
			rev_s2 <= rev_s1;
			vis_yaw_s2 <= vis_yaw_s1;
			vis_pitch_s2 <= vis_pitch_s1;
			mot_pitch_s2 <= mot_pitch_s1;
			dy_s2 <= rnd_y[PW-2:STICK_FRAC];
			dp_s2 <= rnd_p[PW-2:STICK_FRAC];
			yaw_hi_s2 <= astk_y >= AW'(STICK_HI);
			pitch_hi_s2 <= astk_p >= AW'(STICK_HI);
			both_lo_s2 <= (astk_y <= AW'(STICK_LO)) && (astk_p <= AW'(STICK_LO));
			yaw_neg_s2 <= stk_yaw_s1[STICK_W-1];
			pitch_neg_s2 <= stk_pitch_s1[STICK_W-1];
		end
	end

	// stage 3: state update and result
	pwr_state_t          phase_q, phase_n;
	logic signed [W-1:0] yaw_ref_q, pitch_ref_q;
	logic                pom_q, armed_q;
	logic [31:0]         since_q;

	logic                working, rev_ok, rev_take, yaw_fire, pitch_fire, rearm;
	logic signed [W-1:0] last_pitch;
	logic signed [SW-1:0] sum_y, sum_p;
	logic signed [W-1:0] yaw_wr, pitch_wr, pitch_lo, pitch_cl;

	always_comb begin
		if (!pwr_on_s2) begin
			phase_n = PWR_DEAD;
		end else begin
			unique case (phase_q)
				PWR_DEAD:      phase_n = PWR_RESURRECT;
				PWR_RESURRECT: phase_n = any_s2 ? PWR_WORKING : PWR_RESURRECT;
				PWR_WORKING:   phase_n = PWR_WORKING;
				default:       phase_n = PWR_DEAD;
			endcase
		end
	end

	assign working = (phase_n == PWR_WORKING);
	assign last_pitch = pom_q ? pitch_ref_q : mot_pitch_s2;
	assign rev_ok = rev_s2 && (since_q >= 32'(REV_GAP)) && (since_q != '1);

	always_comb begin
		rev_take = 1'b0;
		yaw_fire = 1'b0;
		pitch_fire = 1'b0;
		rearm = 1'b0;
		sum_y = '0;
		sum_p = '0;
		if (auto_s2) begin
			if (win_s2) begin
				sum_y = SW'(vis_yaw_s2);
				sum_p = SW'(vis_pitch_s2);
			end
		end else if (!test_s2) begin
			rev_take = rev_ok;
			sum_y = SW'(yaw_ref_q) + (rev_ok ? PI_V : SW'(dy_s2));
			sum_p = SW'(last_pitch) + SW'(dp_s2);
		end else begin
			yaw_fire = yaw_hi_s2 && armed_q;
			pitch_fire = !yaw_fire && pitch_hi_s2 && armed_q;
			rearm = both_lo_s2 && !armed_q;
			sum_y = SW'(yaw_ref_q);
			sum_p = SW'(last_pitch);
			if (yaw_fire) begin
				sum_y = SW'(yaw_ref_q) + (yaw_neg_s2 ? -STEP10_V : STEP10_V);
			end
			if (pitch_fire) begin
				sum_p = SW'(last_pitch) + (pitch_neg_s2 ? -STEP5_V : STEP5_V);
			end
		end
	end

	ags_wrap #(.ANGLE_WIDTH(W)) u_wrap_yaw (
		.sum     (sum_y),
		.wrapped (yaw_wr)
	);

	ags_wrap #(.ANGLE_WIDTH(W)) u_wrap_pitch (
		.sum     (sum_p),
		.wrapped (pitch_wr)
	);

	// raise to min first, then lower to max
	assign pitch_lo = (pitch_wr < pitch_min_q) ? pitch_min_q : pitch_wr;
	assign pitch_cl = (pitch_lo > pitch_max_q) ? pitch_max_q : pitch_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PWR_DEAD;
			yaw_ref_q <= '0;
			pitch_ref_q <= '0;
			pom_q <= 1'b0;
			armed_q <= 1'b1;
			since_q <= '0;
		end else if (adv2) begin
			phase_q <= phase_n;
			since_q <= (working && rev_take) ? '0 : since_q + 32'd1;
			if (working) begin
				yaw_ref_q <= yaw_wr;
				pitch_ref_q <= pitch_cl;
				pom_q <= 1'b1;
				if (yaw_fire || pitch_fire) begin
					armed_q <= 1'b0;
				end else if (rearm) begin
					armed_q <= 1'b1;
				end
			end else begin
				yaw_ref_q <= '0;
				pitch_ref_q <= '0;
				pom_q <= 1'b0;
			end
		end
	end

	assign yaw_reference = yaw_ref_q;
	assign pitch_reference = pitch_ref_q;
	assign power_state = phase_q;

endmodule

FILE: src/ags_checker.sv
// Port-level checker for the gimbal angle setpoint generator, bound to the top level.
module ags_checker #(
	parameter int ANGLE_WIDTH = ags_pkg::ANGLE_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [ANGLE_WIDTH-1:0] yaw_reference,
	input logic signed [ANGLE_WIDTH-1:0] pitch_reference,
	input logic [1:0]                    power_state
);
	import ags_pkg::*;

	// outside working both references are zero
	a_idle_refs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (power_state != PWR_WORKING) |->
			(yaw_reference == '0) && (pitch_reference == '0))
		else $error("reference nonzero outside working state");

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(yaw_reference) && $stable(pitch_reference)
			&& $stable(power_state))
		else $error("stalled result beat changed");

	// with no result pending the input side never stalls
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output empty");

	// a dead result beat is never followed directly by a working one
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (power_state == PWR_DEAD) ##1
			out_valid && in_valid && $past(in_valid) |-> power_state != PWR_WORKING)
		else $error("power state skipped resurrection");

endmodule

bind gimbal_angle_setpoint_generator ags_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_ags_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.yaw_reference   (yaw_reference),
	.pitch_reference (pitch_reference),
	.power_state     (power_state)
);
